// ----- hw/rtl/plc_pkg.sv -----
`default_nettype none

package plc_pkg;

	localparam int DEPTH       = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int SLOT_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int OP_W        = 3;
	localparam int VALUE_W     = 32;
	localparam int POS_W       = 5;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;
	localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
	localparam logic [OP_W-1:0] OP_READ_AT   = 3'd6;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic load;
		logic decode;
		logic walk_step;
		logic commit_a;
		logic commit_b;
	} plc_cmd_t;

	typedef struct packed {
		logic bad;
		logic walk_done;
	} plc_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/positional_circular_list.sv -----
// Positional circular list: an ordered list of up to DEPTH values, kept as a
// circular chain of links in a slot memory, addressed by one-based position.
//
// Command channel: drive op, value and position and raise start; the beat is
// taken at the rising edge where start is high and busy is low. busy stays
// high until the result has been presented.
// Result channel: done is high for exactly one cycle, with status,
// element_count and read_value valid in that cycle. The receiver cannot
// stall it, so results must be taken as they come.
// Sequence: a decode state, then a walk state that follows one link per step
// until the step count runs out, then the write-back states CMT_A and CMT_B
// and the result state. A positional op at position p walks p-1 links
// (delete at position walks p, delete at back walks count-1, insert at back
// none). A rejected command goes from decode straight to the result state.
// The next command is taken only after the result beat, once busy is low.
// The link walk is bound by the single read port of the link memory.
// Reset: the list is empty and every slot is free; no clearing pass runs.
`default_nettype none

module positional_circular_list import plc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [OP_W-1:0]        op,
	input  wire logic [VALUE_W-1:0]     value,
	input  wire logic [POS_W-1:0]       position,
	output logic                        done,
	output logic [STATUS_W-1:0]         status,
	output logic [COUNT_OUT_W-1:0]      element_count,
	output logic [VALUE_W-1:0]          read_value
);

	plc_cmd_t  cmd;
	plc_stat_t stat;

	plc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	plc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.op            (op),
		.value         (value),
		.position      (position),
		.stat          (stat),
		.status        (status),
		.element_count (element_count),
		.read_value    (read_value)
	);

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy still high after result beat");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (element_count <= COUNT_OUT_W'(DEPTH)))
		else $error("element count above depth");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (element_count == COUNT_OUT_W'(DEPTH)))
		else $error("full status with room left");

	a_no_read_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> (read_value == '0))
		else $error("read value on rejected command");

endmodule

`default_nettype wire

// ----- hw/rtl/plc_ctrl.sv -----
`default_nettype none

module plc_ctrl import plc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire plc_stat_t stat,
	output plc_cmd_t       cmd,
	output logic           busy,
	output logic           done
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_WALK   = 3'd2;
	localparam logic [2:0] S_CMT_A  = 3'd3;
	localparam logic [2:0] S_CMT_B  = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = stat.bad ? S_RESP : S_WALK;
			end
			S_WALK: begin
				// advance one link per cycle until the step count runs out
				if (stat.walk_done) begin
					state_d = S_CMT_A;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_CMT_A: begin
				cmd.commit_a = 1'b1;
				state_d      = S_CMT_B;
			end
			S_CMT_B: begin
				cmd.commit_b = 1'b1;
				state_d      = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

`default_nettype wire

// ----- hw/rtl/plc_dp.sv -----
`default_nettype none

module plc_dp import plc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire plc_cmd_t               cmd,
	input  wire logic [OP_W-1:0]        op,
	input  wire logic [VALUE_W-1:0]     value,
	input  wire logic [POS_W-1:0]       position,
	output plc_stat_t                   stat,
	output logic [STATUS_W-1:0]         status,
	output logic [COUNT_OUT_W-1:0]      element_count,
	output logic [VALUE_W-1:0]          read_value
);

	logic [DATA_WIDTH-1:0] entry_mem [DEPTH];
	logic [SLOT_W-1:0]     link_mem  [DEPTH];

	logic [OP_W-1:0]       op_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [POS_W-1:0]      pos_q;

	logic [OP_W-1:0]       eff_op_q;
	logic [STATUS_W-1:0]   status_q;
	logic [CNT_W-1:0]      remain_q;
	logic                  first_q;
	logic [SLOT_W-1:0]     n_q;
	logic [SLOT_W-1:0]     head_q;
	logic [SLOT_W-1:0]     tail_q;
	logic [DEPTH-1:0]      free_q;
	logic [CNT_W-1:0]      count_q;
	logic [SLOT_W-1:0]     p1_q;
	logic [SLOT_W-1:0]     p2_q;
	logic [SLOT_W-1:0]     link_rd_q;
	logic [DATA_WIDTH-1:0] entry_rd_q;

	logic [OP_W-1:0]       dec_op;
	logic [STATUS_W-1:0]   dec_st;
	logic [CNT_W-1:0]      dec_steps;
	logic [CMP_W-1:0]      pos_x;
	logic [CMP_W-1:0]      cnt_x;
	logic                  full;
	logic                  empty;
	logic                  multi;
	logic [SLOT_W-1:0]     free_slot;
	logic [SLOT_W-1:0]     cur;

	logic                  link_we;
	logic [SLOT_W-1:0]     link_wa;
	logic [SLOT_W-1:0]     link_wd;

	assign pos_x = CMP_W'(pos_q);
	assign cnt_x = CMP_W'(count_q);
	assign full  = (count_q >= CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign multi = (count_q > CNT_W'(1));

	// range-check positional ops, then map onto front/back where they coincide
	always_comb begin
		dec_op    = op_q;
		dec_st    = ST_DONE;
		dec_steps = '0;
		case (op_q)
			OP_INS_AT: begin
				if (full) begin
					dec_st = ST_FULL;
				end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
					dec_st = ST_IGNORED;
				end else if (pos_x == CMP_W'(1)) begin
					dec_op = OP_INS_FIRST;
				end else if (pos_x == cnt_x + CMP_W'(1)) begin
					dec_op = OP_INS_LAST;
				end
			end
			OP_DEL_AT: begin
				if (pos_x == '0 || pos_x > cnt_x) begin
					dec_st = ST_IGNORED;
				end else if (pos_x == CMP_W'(1)) begin
					dec_op = OP_DEL_FIRST;
				end else if (pos_x == cnt_x) begin
					dec_op = OP_DEL_LAST;
				end
			end
			default: begin
			end
		endcase
		if (dec_st == ST_DONE) begin
			case (dec_op)
				OP_INS_FIRST, OP_INS_LAST: begin
					if (full) begin
						dec_st = ST_FULL;
					end
				end
				OP_INS_AT: begin
					dec_steps = CNT_W'(pos_x - CMP_W'(1));
				end
				OP_DEL_FIRST: begin
					if (empty) begin
						dec_st = ST_IGNORED;
					end else if (multi) begin
						dec_steps = CNT_W'(1);
					end
				end
				OP_DEL_LAST: begin
					if (empty) begin
						dec_st = ST_IGNORED;
					end else if (multi) begin
						dec_steps = count_q - CNT_W'(1);
					end
				end
				OP_DEL_AT: begin
					dec_steps = CNT_W'(pos_x);
				end
				OP_READ_AT: begin
					if (pos_x == '0 || pos_x > cnt_x) begin
						dec_st = ST_IGNORED;
					end else begin
						dec_steps = CNT_W'(pos_x - CMP_W'(1));
					end
				end
				default: begin
					dec_st = ST_IGNORED;
				end
			endcase
		end
	end

	// lowest-numbered free slot
	always_comb begin
		free_slot = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end

	assign cur = first_q ? head_q : link_rd_q;

	always_comb begin
		link_we = 1'b0;
		link_wa = '0;
		link_wd = '0;
		if (cmd.commit_a) begin
			case (eff_op_q)
				OP_INS_FIRST, OP_INS_LAST: begin
					link_we = 1'b1;
					if (empty) begin
						link_wa = n_q;
						link_wd = n_q;
					end else if (eff_op_q == OP_INS_FIRST) begin
						link_wa = n_q;
						link_wd = head_q;
					end else begin
						link_wa = tail_q;
						link_wd = n_q;
					end
				end
				OP_INS_AT: begin
					link_we = 1'b1;
					link_wa = n_q;
					link_wd = cur;
				end
				OP_DEL_FIRST: begin
					link_we = multi;
					link_wa = tail_q;
					link_wd = cur;
				end
				OP_DEL_LAST: begin
					link_we = multi;
					link_wa = p1_q;
					link_wd = head_q;
				end
				OP_DEL_AT: begin
					link_we = 1'b1;
					link_wa = p2_q;
					link_wd = cur;
				end
				default: begin
				end
			endcase
		end else if (cmd.commit_b) begin
			case (eff_op_q)
				OP_INS_FIRST: begin
					link_we = !empty;
					link_wa = tail_q;
					link_wd = n_q;
				end
				OP_INS_LAST: begin
					link_we = !empty;
					link_wa = n_q;
					link_wd = head_q;
				end
				OP_INS_AT: begin
					link_we = 1'b1;
					link_wa = p1_q;
					link_wd = n_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (cmd.walk_step) begin
			link_rd_q <= link_mem[cur];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_a && (eff_op_q == OP_INS_FIRST || eff_op_q == OP_INS_LAST ||
				eff_op_q == OP_INS_AT)) begin
			entry_mem[n_q] <= value_q;
		end
		if (cmd.commit_a && eff_op_q == OP_READ_AT) begin
			entry_rd_q <= entry_mem[cur];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			value_q <= DATA_WIDTH'(value);
			pos_q   <= position;
		end
		if (cmd.decode) begin
			n_q <= free_slot;
		end
		if (cmd.walk_step) begin
			p1_q <= cur;
			p2_q <= p1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_op_q <= OP_INS_FIRST;
			status_q <= ST_DONE;
			remain_q <= '0;
			first_q  <= 1'b1;
			head_q   <= '0;
			tail_q   <= '0;
			free_q   <= '1;
			count_q  <= '0;
		end else begin
			if (cmd.decode) begin
				eff_op_q <= dec_op;
				status_q <= dec_st;
				remain_q <= dec_steps;
				first_q  <= 1'b1;
			end
			if (cmd.walk_step) begin
				remain_q <= remain_q - CNT_W'(1);
				first_q  <= 1'b0;
			end
			if (cmd.commit_a) begin
				case (eff_op_q)
					OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
						free_q[n_q] <= 1'b0;
						if (empty) begin
							head_q <= n_q;
							tail_q <= n_q;
						end
					end
					OP_DEL_FIRST: begin
						free_q[head_q] <= 1'b1;
						count_q        <= count_q - CNT_W'(1);
						if (multi) begin
							head_q <= cur;
						end
					end
					OP_DEL_LAST: begin
						count_q <= count_q - CNT_W'(1);
						if (multi) begin
							free_q[tail_q] <= 1'b1;
							tail_q         <= p1_q;
						end else begin
							free_q[head_q] <= 1'b1;
						end
					end
					OP_DEL_AT: begin
						free_q[p1_q] <= 1'b1;
						count_q      <= count_q - CNT_W'(1);
					end
					default: begin
					end
				endcase
			end
			if (cmd.commit_b) begin
				case (eff_op_q)
					OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
						count_q <= count_q + CNT_W'(1);
						if (!empty && eff_op_q == OP_INS_FIRST) begin
							head_q <= n_q;
						end
						if (!empty && eff_op_q == OP_INS_LAST) begin
							tail_q <= n_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign stat.bad       = (dec_st != ST_DONE);
	assign stat.walk_done = (remain_q == '0);

	assign status        = status_q;
	assign element_count = COUNT_OUT_W'(count_q);
	assign read_value    = (eff_op_q == OP_READ_AT && status_q == ST_DONE) ?
		VALUE_W'(entry_rd_q) : '0;

endmodule

`default_nettype wire
